// ----- rtl/ordered_list_table_unit_macros.svh -----
// Assertion macros used by the checker of the ordered list table.
`ifndef ORDERED_LIST_TABLE_UNIT_MACROS_SVH
`define ORDERED_LIST_TABLE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OLT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered list table: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define OLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list table: next-cycle check failed");

`endif

// ----- rtl/olt_pkg.sv -----
package olt_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int ACT_W   = 2;
    localparam int ST_W    = 2;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
    } t_res;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

// ----- rtl/olt_store.sv -----
module olt_store (
    input  logic                         i_clk,
    input  olt_pkg::t_mem_req            i_req,
    output logic [olt_pkg::DATA_W-1:0]   o_rdata
);
    import olt_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/olt_seq.sv -----
module olt_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  olt_pkg::t_cmd                i_cmd,
    output logic                         busy,
    output logic                         o_strobe,
    output olt_pkg::t_res                o_res,
    output olt_pkg::t_mem_req            o_mem_req,
    input  logic [olt_pkg::DATA_W-1:0]   i_rdata
);
    import olt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_SH_RD = 3'd3;
    localparam logic [2:0] S_SH_WR = 3'd4;

    logic [2:0]        r_state,  n_state;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic [ADDR_W-1:0] r_addr,   n_addr;
    logic [ADDR_W-1:0] r_pos,    n_pos;
    logic [ACT_W-1:0]  r_action, n_action;
    logic [DATA_W-1:0] r_value,  n_value;
    logic              r_strobe, n_strobe;
    t_res              r_res,    n_res;

    logic              match;
    logic              at_head;
    logic [ADDR_W-1:0] head_addr;
    logic [ADDR_W-1:0] found_pos;

    // Entries are stored oldest first: the head of the list sits at address
    // count - 1, so an insert is a single write and the scan runs downwards.
    assign match     = (i_rdata == r_value);
    assign head_addr = ADDR_W'(r_count - CNT_W'(1));
    assign at_head   = (CNT_W'(r_addr) == (r_count - CNT_W'(1)));
    assign found_pos = ADDR_W'(r_count - CNT_W'(1) - CNT_W'(r_addr));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_addr    = r_addr;
        n_pos     = r_pos;
        n_action  = r_action;
        n_value   = r_value;
        n_strobe  = 1'b0;
        n_res     = r_res;
        o_mem_req = '{we: 1'b0, waddr: r_addr, wdata: r_value, re: 1'b0, raddr: r_addr};

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_action = i_cmd.action;
                    n_value  = i_cmd.value;
                    priority if (i_cmd.action == ACT_INSERT) begin
                        n_strobe = 1'b1;
                        n_res.position = POS_W'(0);
                        if (r_count == CNT_W'(DEPTH)) begin
                            n_res.status = ST_FULL;
                            n_res.count  = COUNT_W'(r_count);
                        end else begin
                            o_mem_req.we    = 1'b1;
                            o_mem_req.waddr = ADDR_W'(r_count);
                            o_mem_req.wdata = i_cmd.value;
                            n_count         = r_count + CNT_W'(1);
                            n_res.status    = ST_OK;
                            n_res.count     = COUNT_W'(r_count + CNT_W'(1));
                        end
                    end else if ((i_cmd.action == ACT_DELETE) ||
                                 (i_cmd.action == ACT_LOOKUP)) begin
                        if (r_count == '0) begin
                            n_strobe       = 1'b1;
                            n_res.status   = ST_NOT_FOUND;
                            n_res.position = POS_W'(0);
                            n_res.count    = COUNT_W'(r_count);
                        end else begin
                            n_addr  = head_addr;
                            n_state = S_RD;
                        end
                    end else begin
                        n_strobe       = 1'b1;
                        n_res.status   = ST_NOT_FOUND;
                        n_res.position = POS_W'(0);
                        n_res.count    = COUNT_W'(r_count);
                    end
                end
            end
            S_RD: begin
                o_mem_req.re = 1'b1;
                n_state      = S_CMP;
            end
            S_CMP: begin
                if (match) begin
                    n_pos = found_pos;
                    if ((r_action == ACT_LOOKUP) || at_head) begin
                        if (r_action == ACT_DELETE) begin
                            n_count = r_count - CNT_W'(1);
                        end
                        n_strobe       = 1'b1;
                        n_res.status   = ST_OK;
                        n_res.position = POS_W'(found_pos);
                        n_res.count    = (r_action == ACT_DELETE) ?
                                         COUNT_W'(r_count - CNT_W'(1)) : COUNT_W'(r_count);
                        n_state        = S_IDLE;
                    end else begin
                        n_addr  = r_addr + ADDR_W'(1);
                        n_state = S_SH_RD;
                    end
                end else if (r_addr == '0) begin
                    n_strobe       = 1'b1;
                    n_res.status   = ST_NOT_FOUND;
                    n_res.position = POS_W'(0);
                    n_res.count    = COUNT_W'(r_count);
                    n_state        = S_IDLE;
                end else begin
                    n_addr  = r_addr - ADDR_W'(1);
                    n_state = S_RD;
                end
            end
            S_SH_RD: begin
                o_mem_req.re = 1'b1;
                n_state      = S_SH_WR;
            end
            S_SH_WR: begin
                // Each newer entry moves one place down to close the gap.
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_addr - ADDR_W'(1);
                o_mem_req.wdata = i_rdata;
                if (at_head) begin
                    n_count        = r_count - CNT_W'(1);
                    n_strobe       = 1'b1;
                    n_res.status   = ST_OK;
                    n_res.position = POS_W'(r_pos);
                    n_res.count    = COUNT_W'(r_count - CNT_W'(1));
                    n_state        = S_IDLE;
                end else begin
                    n_addr  = r_addr + ADDR_W'(1);
                    n_state = S_SH_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_pos    <= n_pos;
        r_action <= n_action;
        r_value  <= n_value;
        r_res    <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

// ----- rtl/ordered_list_table_unit.sv -----
// Bounded list of up to 16 signed 32-bit values, newest at position 0. A command is taken
// when start is high and busy is low; its single result appears on o_res for exactly one
// cycle with o_strobe high, and the receiver cannot stall it. An insert, a rejected insert,
// an unused action code or a search of an empty list gives its result in the cycle after
// the command. Lookup and delete walk the list from the head through a register file with
// one read and one write port, reading and then comparing each entry; a delete then moves
// every newer entry one place down, a read and a write for each, to close the gap. A new
// command may be issued in the same cycle as the previous result's strobe.
module ordered_list_table_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  olt_pkg::t_cmd     i_cmd,
    output logic              busy,
    output logic              o_strobe,
    output olt_pkg::t_res     o_res
);
    import olt_pkg::*;

    t_mem_req          mem_req;
    logic [DATA_W-1:0] mem_rdata;

    olt_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_cmd     (i_cmd),
        .busy      (busy),
        .o_strobe  (o_strobe),
        .o_res     (o_res),
        .o_mem_req (mem_req),
        .i_rdata   (mem_rdata)
    );

    olt_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

// ----- rtl/olt_checker.sv -----
`include "ordered_list_table_unit_macros.svh"

module olt_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          busy,
    input  logic          o_strobe,
    input  olt_pkg::t_res o_res
);
    import olt_pkg::*;

    // An accepted transaction either finishes at once or keeps the unit busy.
    `OLT_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_strobe)

    // A result is never shown while the unit still reports itself busy.
    `OLT_ASSERT_SAME(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy)

    // A result only follows an accepted transaction or a busy period.
    `OLT_ASSERT_SAME(a_strobe_cause, i_clk, i_rst_n, o_strobe, $past(busy) || $past(start))

    `OLT_ASSERT_SAME(a_pos_zero, i_clk, i_rst_n, o_strobe && (o_res.status != ST_OK), o_res.position == '0)

    `OLT_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, o_strobe, o_res.count <= COUNT_W'(DEPTH))

endmodule

bind ordered_list_table_unit olt_checker u_olt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_res    (o_res)
);

// ----- tb/sv/olt_list_checker.sv -----
`timescale 1ns / 100ps

module olt_list_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  olt_pkg::t_cmd  i_cmd,
    input  logic           i_busy,
    input  logic           i_strobe,
    input  olt_pkg::t_res  i_res,
    output int             o_pending,
    output int             o_fail_count
);
    import olt_pkg::*;

    // Shadow copy of the list, head at index 0.
    logic [DATA_W-1:0] shadow_vals [DEPTH];
    int                shadow_len = 0;
    t_res              pending_results [$];
    int                fails = 0;

    // Applies one command to the shadow list and returns the result it should produce.
    function automatic t_res apply_list_command(t_cmd c);
        t_res r;
        int   hit;
        r.status   = ST_NOT_FOUND;
        r.position = '0;
        hit        = -1;
        case (c.action)
            ACT_INSERT: begin
                if (shadow_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = shadow_len; i > 0; i--) begin
                        shadow_vals[i] = shadow_vals[i-1];
                    end
                    shadow_vals[0] = c.value;
                    shadow_len++;
                    r.status = ST_OK;
                end
            end
            ACT_DELETE, ACT_LOOKUP: begin
                // Walking from the tail leaves the match nearest the head in hit.
                for (int i = shadow_len - 1; i >= 0; i--) begin
                    if (shadow_vals[i] == c.value) begin
                        hit = i;
                    end
                end
                if (hit >= 0) begin
                    r.status   = ST_OK;
                    r.position = hit[POS_W-1:0];
                    if (c.action == ACT_DELETE) begin
                        for (int i = hit; i < shadow_len - 1; i++) begin
                            shadow_vals[i] = shadow_vals[i+1];
                        end
                        shadow_len--;
                    end
                end
            end
            default: ;
        endcase
        r.count = shadow_len[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            shadow_len = 0;
            pending_results.delete();
        end else begin
            // A result is checked before the command of the same edge is predicted, since a
            // new command may be taken in the cycle of the previous strobe.
            if (i_strobe) begin
                if (pending_results.size() == 0) begin
                    $error("result with none outstanding: status %0d position %0d count %0d",
                           i_res.status, i_res.position, i_res.count);
                    fails++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_res.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_res.status);
                        fails++;
                    end
                    if (i_res.position !== want.position) begin
                        $error("position: expected %0d, actual %0d", want.position,
                               i_res.position);
                        fails++;
                    end
                    if (i_res.count !== want.count) begin
                        $error("count: expected %0d, actual %0d", want.count, i_res.count);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                pending_results.push_back(apply_list_command(i_cmd));
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= fails;
    end

endmodule

// ----- tb/sv/ordered_list_table_unit_tb.sv -----
`timescale 1ns / 100ps

module ordered_list_table_unit_tb;
    import olt_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_PER_PHASE = 650;
    localparam int BLOCK_LEN        = 40;
    localparam int DRAIN_CYCLES     = 100;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_cmd cmd     = '0;
    logic busy;
    logic res_strobe;
    t_res res;
    logic cmd_taken = 1'b0;
    int   pending;
    int   fail_count;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ordered_list_table_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (cmd),
        .busy     (busy),
        .o_strobe (res_strobe),
        .o_res    (res)
    );

    olt_list_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_cmd        (cmd),
        .i_busy       (busy),
        .i_strobe     (res_strobe),
        .i_res        (res),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Records whether the command on the inputs was taken at the last rising edge.
    always @(posedge i_clk) begin
        cmd_taken <= i_rst_n && start && !busy;
    end

    // Called at a falling edge; returns at a falling edge once the command has been taken.
    task automatic send_command(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val);
        start      <= 1'b1;
        cmd.action <= act;
        cmd.value  <= val;
        @(negedge i_clk);
        while (!cmd_taken) begin
            @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        #10_000_000;
        $display("ordered_list_table_unit verification failed");
        $finish;
    end

    initial begin
        logic [DATA_W-1:0] value_pool [8];
        logic [ACT_W-1:0]  act;
        logic [DATA_W-1:0] val;
        int                idle_pct;
        int                insert_pct;
        int                pick;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Searches of an empty list, then the extreme values and an unused action code.
        send_command(ACT_LOOKUP, 32'h0000_0000);
        send_command(ACT_DELETE, 32'h0000_0000);
        send_command(ACT_INSERT, 32'h8000_0000);
        send_command(ACT_INSERT, 32'h7FFF_FFFF);
        send_command(ACT_INSERT, 32'h0000_0000);
        send_command(ACT_INSERT, 32'hFFFF_FFFF);
        send_command(ACT_LOOKUP, 32'h8000_0000);
        send_command(ACT_LOOKUP, 32'h0000_0005);
        send_command(ACT_UNUSED, 32'hA5A5_A5A5);
        // Fill the list, with a duplicate of an existing value among the new entries.
        send_command(ACT_INSERT, 32'h7FFF_FFFF);
        for (int k = 1; k <= 11; k++) begin
            send_command(ACT_INSERT, k * 32'h0101_0101);
        end
        send_command(ACT_INSERT, 32'h1234_5678);
        send_command(ACT_LOOKUP, 32'h8000_0000);
        send_command(ACT_DELETE, 32'h7FFF_FFFF);
        send_command(ACT_LOOKUP, 32'h7FFF_FFFF);
        send_command(ACT_DELETE, 32'h8000_0000);
        send_command(ACT_DELETE, 32'h0B0B_0B0B);

        insert_pct = 40;
        for (int ph = 0; ph < 3; ph++) begin
            drain_results();
            @(negedge i_clk);
            idle_pct = (ph == 0) ? 20 : (ph == 1) ? 75 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // Each block draws a fresh pool of values so that deletes and lookups hit
                // entries that are really held, and swings the list between full and empty.
                if (n % BLOCK_LEN == 0) begin
                    case ($urandom_range(2))
                        0: insert_pct = 15;
                        1: insert_pct = 45;
                        default: insert_pct = 70;
                    endcase
                    for (int k = 0; k < 8; k++) begin
                        value_pool[k] = $urandom;
                    end
                end
                pick = $urandom_range(99);
                if (pick < insert_pct) begin
                    act = ACT_INSERT;
                end else if (pick < insert_pct + (95 - insert_pct) / 2) begin
                    act = ACT_DELETE;
                end else if (pick < 95) begin
                    act = ACT_LOOKUP;
                end else begin
                    act = ACT_UNUSED;
                end
                val = ($urandom_range(3) == 0) ? $urandom : value_pool[$urandom_range(7)];
                send_command(act, val);
                if ($urandom_range(99) < idle_pct) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(negedge i_clk);
                end
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ordered_list_table_unit verification clean");
        end else begin
            $display("ordered_list_table_unit verification failed");
        end
        $finish;
    end

endmodule
